### hw/rtl/ttt_pkg.sv
// Shared types and constants of the time-triggered task table.
`default_nettype none

package ttt_pkg;

    typedef enum logic [1:0] {
        ACT_ADD      = 2'd0,
        ACT_DELETE   = 2'd1,
        ACT_OVERFLOW = 2'd2,
        ACT_DISPATCH = 2'd3
    } action_t;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;
    localparam logic [1:0] STAT_NONE  = 2'd3;

    localparam logic [7:0] RUNS_MAX  = 8'hFF;
    localparam logic [7:0] OPT_RESET = 8'd8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_DELETE,
        S_OVFL,
        S_TICK,
        S_DISP,
        S_REPLY
    } state_t;

    typedef enum logic {
        MODE_TICK,
        MODE_DISPATCH
    } alu_mode_t;

    typedef struct packed {
        logic [7:0]  task_id;
        logic [15:0] delay;
        logic [15:0] period;
        logic [7:0]  runs;
    } slot_entry_t;

    typedef struct packed {
        logic we;     // write the updated entry back
        logic ready;  // dispatch: slot has a pending run
        logic clear;  // dispatch: one-shot slot is freed
    } alu_flags_t;

endpackage

`default_nettype wire

### hw/rtl/ttt_slot_alu.sv
// Shared per-slot update unit: tick countdown and dispatch run take.
`default_nettype none

module ttt_slot_alu
    import ttt_pkg::*;
(
    input  alu_mode_t   mode,
    input  logic        ent_valid,
    input  slot_entry_t ent_in,
    output slot_entry_t ent_out,
    output alu_flags_t  flags
);

    always_comb begin
        ent_out = ent_in;
        flags   = '0;
        unique case (mode)
            MODE_TICK: begin
                if (ent_valid) begin
                    flags.we = 1'b1;
                    if (ent_in.delay == '0) begin
                        if (ent_in.runs != RUNS_MAX) begin
                            ent_out.runs = ent_in.runs + 8'd1;
                        end
                        if (ent_in.period != '0) begin
                            ent_out.delay = ent_in.period;
                        end
                    end else begin
                        ent_out.delay = ent_in.delay - 16'd1;
                    end
                end
            end
            MODE_DISPATCH: begin
                if (ent_valid && (ent_in.runs != '0)) begin
                    flags.ready  = 1'b1;
                    ent_out.runs = ent_in.runs - 8'd1;
                    // one shot: freed on first dispatch, no write back needed
                    flags.clear  = (ent_in.period == '0);
                    flags.we     = (ent_in.period != '0);
                end
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/time_triggered_task_table.sv
// Top level of the time-triggered task table of a cooperative scheduler.
// Delete and overflow without tick pass through their state, S_REPLY and the output register;
// add first searches for a free slot, and a ticking overflow first walks every slot.
// Dispatch walks the table one slot per cycle unless a found slot waits for the output.
// Throughput: one item at a time; s_ready is high only in S_IDLE.
// Reset (aresetn low, synchronous): slots invalid, counters zero, overflows_per_tick = 8;
// slot memory is not cleared, the per-slot valid bits mask it.
`default_nettype none

module time_triggered_task_table
    import ttt_pkg::*;
#(
    parameter int MAX_TASKS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic [7:0]  s_task_id,
    input  wire logic [15:0] s_delay,
    input  wire logic [15:0] s_period,
    input  wire logic [2:0]  s_slot,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [2:0]       m_slot_out,
    output logic [7:0]       m_ready_task,
    output logic [31:0]      m_tick_count,
    output logic             m_last,
    // configuration write channel: overflows_per_tick
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data
);

    localparam int IDXW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int SW   = IDXW + 3;
    localparam logic [IDXW-1:0] IDX_LAST = IDXW'(MAX_TASKS - 1);

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    state_t               state_reg, state_next;
    logic [IDXW-1:0]      idx_reg, idx_next;
    logic [MAX_TASKS-1:0] valid_reg, valid_next;
    logic [7:0]           ovf_count_reg, ovf_count_next;
    logic [31:0]          ticks_reg, ticks_next;
    logic [7:0]           opt_reg, opt_next;

    // latched input beat
    logic [7:0]           task_reg, task_next;
    logic [15:0]          delay_reg, delay_next;
    logic [15:0]          period_reg, period_next;
    logic [2:0]           slot_reg, slot_next;

    // pending reply; during dispatch it holds the last ready slot found
    logic [1:0]           rep_status_reg, rep_status_next;
    logic [2:0]           rep_slot_reg, rep_slot_next;
    logic [7:0]           rep_task_reg, rep_task_next;
    logic                 pend_reg, pend_next;

    // output register
    logic                 m_valid_reg, m_valid_next;
    logic [1:0]           m_status_reg, m_status_next;
    logic [2:0]           m_slot_reg, m_slot_next;
    logic [7:0]           m_task_reg, m_task_next;
    logic [31:0]          m_tick_reg, m_tick_next;
    logic                 m_last_reg, m_last_next;

    // slot memory: one write and one registered read port
    slot_entry_t          slot_mem [MAX_TASKS];
    slot_entry_t          rd_data_reg;
    logic                 mem_we, mem_re;
    logic [IDXW-1:0]      mem_waddr, mem_raddr;
    slot_entry_t          mem_wdata;

    // ---------------------------------------------------------------
    // Helpers
    // ---------------------------------------------------------------
    logic                 out_free;
    logic                 idx_last;
    logic [IDXW-1:0]      idx_inc;
    logic [SW-1:0]        idx_wide, slot_wide;
    logic [2:0]           idx3;
    logic [IDXW-1:0]      sidx;
    logic                 slot_in_range;
    logic [7:0]           ovf_inc;
    logic                 tick_now;
    alu_mode_t            alu_mode;
    slot_entry_t          alu_out;
    alu_flags_t           alu_flags;
    logic                 disp_stall;

    assign out_free      = !m_valid_reg || m_ready;
    assign idx_last      = (idx_reg == IDX_LAST);
    assign idx_inc       = idx_reg + IDXW'(1);
    assign idx_wide      = {3'b000, idx_reg};
    assign idx3          = idx_wide[2:0];
    assign slot_wide     = {{IDXW{1'b0}}, slot_reg};
    assign sidx          = slot_wide[IDXW-1:0];
    assign slot_in_range = (slot_wide < SW'(MAX_TASKS));
    assign ovf_inc       = ovf_count_reg + 8'd1;
    assign tick_now      = (ovf_inc == opt_reg);
    assign alu_mode      = (state_reg == S_TICK) ? MODE_TICK : MODE_DISPATCH;
    // a second ready slot can only be taken once the output register is free for the pending one
    assign disp_stall    = alu_flags.ready && pend_reg && !out_free;

    ttt_slot_alu u_alu (
        .mode      (alu_mode),
        .ent_valid (valid_reg[idx_reg]),
        .ent_in    (rd_data_reg),
        .ent_out   (alu_out),
        .flags     (alu_flags)
    );

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    unique case (action_t'(s_action))
                        ACT_ADD:      state_next = S_ADD;
                        ACT_DELETE:   state_next = S_DELETE;
                        ACT_OVERFLOW: state_next = S_OVFL;
                        ACT_DISPATCH: state_next = S_DISP;
                    endcase
                end
            end
            S_ADD: begin
                if (!valid_reg[idx_reg] || idx_last) begin
                    state_next = S_REPLY;
                end
            end
            S_DELETE: state_next = S_REPLY;
            S_OVFL:   state_next = tick_now ? S_TICK : S_REPLY;
            S_TICK: begin
                if (idx_last) begin
                    state_next = S_REPLY;
                end
            end
            S_DISP: begin
                if (!disp_stall && idx_last) begin
                    state_next = S_REPLY;
                end
            end
            S_REPLY: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Datapath and outputs
    // ---------------------------------------------------------------
    always_comb begin
        logic emit;
        logic emit_last;

        emit            = 1'b0;
        emit_last       = 1'b0;
        s_ready         = 1'b0;
        idx_next        = idx_reg;
        valid_next      = valid_reg;
        ovf_count_next  = ovf_count_reg;
        ticks_next      = ticks_reg;
        task_next       = task_reg;
        delay_next      = delay_reg;
        period_next     = period_reg;
        slot_next       = slot_reg;
        rep_status_next = rep_status_reg;
        rep_slot_next   = rep_slot_reg;
        rep_task_next   = rep_task_reg;
        pend_next       = pend_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = idx_reg;
        mem_raddr       = idx_inc;
        mem_wdata       = alu_out;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    task_next   = s_task_id;
                    delay_next  = s_delay;
                    period_next = s_period;
                    slot_next   = s_slot;
                    idx_next    = '0;
                    pend_next   = 1'b0;
                    if (action_t'(s_action) == ACT_DISPATCH) begin
                        mem_re    = 1'b1;
                        mem_raddr = '0;
                    end
                end
            end
            S_ADD: begin
                rep_task_next = '0;
                if (!valid_reg[idx_reg]) begin
                    mem_we              = 1'b1;
                    mem_wdata.task_id   = task_reg;
                    mem_wdata.delay     = delay_reg;
                    mem_wdata.period    = period_reg;
                    mem_wdata.runs      = '0;
                    valid_next[idx_reg] = 1'b1;
                    rep_status_next     = STAT_OK;
                    rep_slot_next       = idx3;
                end else if (idx_last) begin
                    rep_status_next = STAT_FULL;
                    rep_slot_next   = '0;
                end else begin
                    idx_next = idx_inc;
                end
            end
            S_DELETE: begin
                rep_slot_next   = '0;
                rep_task_next   = '0;
                rep_status_next = STAT_EMPTY;
                if (slot_in_range) begin
                    if (valid_reg[sidx]) begin
                        rep_status_next = STAT_OK;
                    end
                    valid_next[sidx] = 1'b0;
                end
            end
            S_OVFL: begin
                rep_status_next = STAT_OK;
                rep_slot_next   = '0;
                rep_task_next   = '0;
                if (tick_now) begin
                    ovf_count_next = '0;
                    idx_next       = '0;
                    mem_re         = 1'b1;
                    mem_raddr      = '0;
                end else begin
                    ovf_count_next = ovf_inc;
                end
            end
            S_TICK: begin
                mem_we = alu_flags.we;
                if (idx_last) begin
                    ticks_next = ticks_reg + 32'd1;
                end else begin
                    idx_next = idx_inc;
                    mem_re   = 1'b1;
                end
            end
            S_DISP: begin
                if (!disp_stall) begin
                    mem_we = alu_flags.we;
                    if (alu_flags.ready) begin
                        // push out the previous ready slot, this one waits
                        emit            = pend_reg;
                        pend_next       = 1'b1;
                        rep_status_next = STAT_OK;
                        rep_slot_next   = idx3;
                        rep_task_next   = rd_data_reg.task_id;
                    end
                    if (alu_flags.clear) begin
                        valid_next[idx_reg] = 1'b0;
                    end
                    if (idx_last) begin
                        if (!pend_reg && !alu_flags.ready) begin
                            rep_status_next = STAT_NONE;
                            rep_slot_next   = '0;
                            rep_task_next   = '0;
                        end
                    end else begin
                        idx_next = idx_inc;
                        mem_re   = 1'b1;
                    end
                end
            end
            S_REPLY: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_last = 1'b1;
                end
            end
            default: ;
        endcase

        // output register: current reply fields, stamped with the tick count
        m_valid_next  = emit || (m_valid_reg && !m_ready);
        m_status_next = emit ? rep_status_reg : m_status_reg;
        m_slot_next   = emit ? rep_slot_reg : m_slot_reg;
        m_task_next   = emit ? rep_task_reg : m_task_reg;
        m_tick_next   = emit ? ticks_reg : m_tick_reg;
        m_last_next   = emit ? emit_last : m_last_reg;

        opt_next = (cfg_valid && cfg_ready) ? cfg_data : opt_reg;
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            valid_reg     <= '0;
            ovf_count_reg <= '0;
            ticks_reg     <= '0;
            opt_reg       <= OPT_RESET;
            pend_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            valid_reg     <= valid_next;
            ovf_count_reg <= ovf_count_next;
            ticks_reg     <= ticks_next;
            opt_reg       <= opt_next;
            pend_reg      <= pend_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        task_reg       <= task_next;
        delay_reg      <= delay_next;
        period_reg     <= period_next;
        slot_reg       <= slot_next;
        rep_status_reg <= rep_status_next;
        rep_slot_reg   <= rep_slot_next;
        rep_task_reg   <= rep_task_next;
        m_status_reg   <= m_status_next;
        m_slot_reg     <= m_slot_next;
        m_task_reg     <= m_task_next;
        m_tick_reg     <= m_tick_next;
        m_last_reg     <= m_last_next;
    end

    // slot memory; entries of invalid slots are don't-care
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= slot_mem[mem_raddr];
        end
    end

    assign cfg_ready    = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_slot_out   = m_slot_reg;
    assign m_ready_task = m_task_reg;
    assign m_tick_count = m_tick_reg;
    assign m_last       = m_last_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // walk writes slot i while fetching slot i+1: never the same entry
    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("slot memory read and write hit the same entry");

    // the overflow counter restarts before a tick walk begins
    a_tick_counter_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TICK) |-> (ovf_count_reg == '0))
        else $error("overflow counter not cleared during tick walk");

    // ticks only advance at the end of a tick walk
    a_ticks_from_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (ticks_reg != $past(ticks_reg))) |->
            ($past(state_reg) == S_TICK))
        else $error("tick count changed outside a tick walk");

    // only dispatch results are followed by more results, and they are ok
    a_non_last_is_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_last_reg) |-> (m_status_reg == STAT_OK))
        else $error("non-final beat with a non-ok status");

endmodule

`default_nettype wire
